@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks are sampled on clock and ignored while reset is high.
`define ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sha1s_pkg.sv @@
package sha1s_pkg;

   localparam int WORD_W       = 32;
   localparam int DIGEST_WORDS = 5;
   localparam int ROUNDS       = 80;
   localparam int BLOCK_BYTES  = 64;
   localparam int BLOCK_W      = 8 * BLOCK_BYTES;
   localparam int LEN_POS      = 56;

   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [63:0] BLOCK_BITS = 64'(BLOCK_W);
   localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [5:0]  LAST_FILL  = 6'(BLOCK_BYTES - 1);
   localparam logic [5:0]  LEN_FILL   = 6'(LEN_POS);
   localparam logic [2:0]  LAST_INDEX = 3'(DIGEST_WORDS - 1);

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   localparam logic [WORD_W-1:0] H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY_LO,
      PH_MAJORITY,
      PH_PARITY_HI
   } phase_type;

   typedef struct packed {
      logic       shift_byte;
      logic [7:0] byte_val;
      logic       shift_word;
   } msg_ctl_type;

   typedef struct packed {
      logic       load;
      logic       step;
      phase_type  phase;
      logic       add;
      logic       init;
      logic [2:0] idx;
   } rnd_ctl_type;

   function automatic logic [WORD_W-1:0] round_k(input phase_type ph);
      logic [WORD_W-1:0] k;
      case (ph)
         PH_CHOOSE:    k = 32'h5A827999;
         PH_PARITY_LO: k = 32'h6ED9EBA1;
         PH_MAJORITY:  k = 32'h8F1BBCDC;
         PH_PARITY_HI: k = 32'hCA62C1D6;
         default:      k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/sha1s_msg.sv @@
module sha1s_msg (
   input  logic                          clock,
   input  sha1s_pkg::msg_ctl_type        msg_ctl,
   output logic [sha1s_pkg::WORD_W-1:0]  w_cur
);

   localparam int BW = sha1s_pkg::BLOCK_W;
   localparam int WW = sha1s_pkg::WORD_W;

   logic [BW-1:0] blk_ff;
   logic [BW-1:0] blk_in;
   logic [WW-1:0] mix;
   logic [WW-1:0] w_next;

   // window: word 0 is W[t], word 15 is W[t+15]
   assign w_cur  = blk_ff[BW-1 -: WW];
   assign mix    = blk_ff[BW-1-13*WW -: WW] ^ blk_ff[BW-1-8*WW -: WW] ^
                   blk_ff[BW-1-2*WW -: WW] ^ blk_ff[BW-1 -: WW];
   assign w_next = {mix[WW-2:0], mix[WW-1]};

   always_comb begin
      blk_in = blk_ff;
      if (msg_ctl.shift_byte) begin
         blk_in = {blk_ff[BW-9:0], msg_ctl.byte_val};
      end else if (msg_ctl.shift_word) begin
         blk_in = {blk_ff[BW-WW-1:0], w_next};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

@@ rtl/sha1s_round.sv @@
module sha1s_round (
   input  logic                          clock,
   input  logic                          reset,
   input  sha1s_pkg::rnd_ctl_type        rnd_ctl,
   input  logic [sha1s_pkg::WORD_W-1:0]  w_cur,
   output logic [sha1s_pkg::WORD_W-1:0]  digest_word
);

   localparam int WW = sha1s_pkg::WORD_W;
   localparam int NW = sha1s_pkg::DIGEST_WORDS;

   logic [WW-1:0] chain_ff [NW];
   logic [WW-1:0] chain_in [NW];
   logic [WW-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [WW-1:0] a_in, b_in, c_in, d_in, e_in;
   logic [WW-1:0] f_val;
   logic [WW-1:0] t_val;

   always_comb begin
      case (rnd_ctl.phase)
         sha1s_pkg::PH_CHOOSE:   f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         sha1s_pkg::PH_MAJORITY: f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default:                f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val = {a_ff[WW-6:0], a_ff[WW-1 -: 5]} + f_val + e_ff +
                  sha1s_pkg::round_k(rnd_ctl.phase) + w_cur;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (rnd_ctl.load) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (rnd_ctl.step) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[WW-1:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (rnd_ctl.init) begin
         chain_in = sha1s_pkg::H_INIT;
      end else if (rnd_ctl.add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   assign digest_word = (rnd_ctl.idx <= sha1s_pkg::LAST_INDEX) ?
                        chain_ff[rnd_ctl.idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1s_pkg::H_INIT;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

endmodule

@@ rtl/sha1_stream_hasher_unit.sv @@
// Streaming SHA-1 hasher. Each req transfer brings one byte to absorb, or a finish
// that pads the message and returns the 160-bit digest as five rsp transfers, word 0
// first, the fifth flagged by rsp_last_word; the unit then starts a new message. An
// absorb of the 64th byte of a block also starts the compression: the SHA-1 rounds run
// through the single shared round unit, then an add into the chaining words, during
// which no new byte is taken. A finish writes one padding byte per cycle up to the
// block end, needing one or two compressions, before the five digest transfers.
// req_stall is high for the whole of that work.
`include "assert_macros.svh"

module sha1_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha1s_pkg::state_type   state_ff, state_in;
   sha1s_pkg::msg_ctl_type msg_ctl;
   sha1s_pkg::rnd_ctl_type rnd_ctl;
   sha1s_pkg::phase_type   phase;

   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  round_ff, round_in;
   logic [63:0] bits_ff, bits_in;
   logic [2:0]  idx_ff, idx_in;
   logic        pad_ff, pad_in;
   logic        len_ok_ff, len_ok_in;
   logic        req_take;
   logic        rsp_take;
   logic        fill_last;
   logic [7:0]  pad_byte;
   logic [31:0] w_cur;

   assign req_take  = req_valid && (state_ff == sha1s_pkg::ST_IDLE);
   assign rsp_take  = (state_ff == sha1s_pkg::ST_EMIT) && !rsp_stall;
   assign fill_last = (fill_ff == sha1s_pkg::LAST_FILL);

   // length bytes go out most significant first at positions 56..63
   assign pad_byte = (len_ok_ff && fill_ff >= sha1s_pkg::LEN_FILL) ?
                     8'(bits_ff >> {~fill_ff[2:0], 3'b000}) : 8'h00;

   always_comb begin
      if (round_ff < 7'd20) begin
         phase = sha1s_pkg::PH_CHOOSE;
      end else if (round_ff < 7'd40) begin
         phase = sha1s_pkg::PH_PARITY_LO;
      end else if (round_ff < 7'd60) begin
         phase = sha1s_pkg::PH_MAJORITY;
      end else begin
         phase = sha1s_pkg::PH_PARITY_HI;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha1s_pkg::ST_IDLE: begin
            if (req_take) begin
               if (fill_last) begin
                  state_in = sha1s_pkg::ST_ROUND;
               end else if (req_action == sha1s_pkg::ACT_FINISH) begin
                  state_in = sha1s_pkg::ST_PAD;
               end
            end
         end
         sha1s_pkg::ST_ROUND: begin
            if (round_ff == sha1s_pkg::LAST_ROUND) begin
               state_in = sha1s_pkg::ST_ADD;
            end
         end
         sha1s_pkg::ST_ADD: begin
            if (!pad_ff) begin
               state_in = sha1s_pkg::ST_IDLE;
            end else if (len_ok_ff) begin
               state_in = sha1s_pkg::ST_EMIT;
            end else begin
               state_in = sha1s_pkg::ST_PAD;
            end
         end
         sha1s_pkg::ST_PAD: begin
            if (fill_last) begin
               state_in = sha1s_pkg::ST_ROUND;
            end
         end
         sha1s_pkg::ST_EMIT: begin
            if (rsp_take && idx_ff == sha1s_pkg::LAST_INDEX) begin
               state_in = sha1s_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1s_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      msg_ctl    = '0;
      rnd_ctl    = '0;
      rnd_ctl.phase = phase;
      rnd_ctl.idx   = idx_ff;
      case (state_ff)
         sha1s_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_take) begin
               msg_ctl.shift_byte = 1'b1;
               msg_ctl.byte_val   = (req_action == sha1s_pkg::ACT_FINISH) ?
                                    sha1s_pkg::PAD_MARK : req_data_byte;
               rnd_ctl.load       = fill_last;
            end
         end
         sha1s_pkg::ST_ROUND: begin
            rnd_ctl.step       = 1'b1;
            msg_ctl.shift_word = 1'b1;
         end
         sha1s_pkg::ST_ADD: begin
            rnd_ctl.add = 1'b1;
         end
         sha1s_pkg::ST_PAD: begin
            msg_ctl.shift_byte = 1'b1;
            msg_ctl.byte_val   = pad_byte;
            rnd_ctl.load       = fill_last;
         end
         sha1s_pkg::ST_EMIT: begin
            rsp_valid    = 1'b1;
            rnd_ctl.init = rsp_take && (idx_ff == sha1s_pkg::LAST_INDEX);
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      fill_in   = fill_ff;
      round_in  = round_ff;
      bits_in   = bits_ff;
      idx_in    = idx_ff;
      pad_in    = pad_ff;
      len_ok_in = len_ok_ff;
      case (state_ff)
         sha1s_pkg::ST_IDLE: begin
            if (req_take) begin
               fill_in = fill_ff + 6'd1;
               if (req_action == sha1s_pkg::ACT_FINISH) begin
                  bits_in   = bits_ff + {55'd0, fill_ff, 3'b000};
                  pad_in    = 1'b1;
                  len_ok_in = (fill_ff < sha1s_pkg::LEN_FILL);
               end else if (fill_last) begin
                  bits_in = bits_ff + sha1s_pkg::BLOCK_BITS;
               end
            end
         end
         sha1s_pkg::ST_ROUND: begin
            round_in = (round_ff == sha1s_pkg::LAST_ROUND) ? 7'd0 : round_ff + 7'd1;
         end
         sha1s_pkg::ST_ADD: begin
            if (pad_ff) begin
               len_ok_in = 1'b1;
            end
         end
         sha1s_pkg::ST_PAD: begin
            fill_in = fill_ff + 6'd1;
         end
         sha1s_pkg::ST_EMIT: begin
            if (rsp_take) begin
               if (idx_ff == sha1s_pkg::LAST_INDEX) begin
                  idx_in    = 3'd0;
                  pad_in    = 1'b0;
                  len_ok_in = 1'b0;
                  bits_in   = '0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha1s_pkg::ST_IDLE;
         fill_ff   <= '0;
         round_ff  <= '0;
         bits_ff   <= '0;
         idx_ff    <= '0;
         pad_ff    <= 1'b0;
         len_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         round_ff  <= round_in;
         bits_ff   <= bits_in;
         idx_ff    <= idx_in;
         pad_ff    <= pad_in;
         len_ok_ff <= len_ok_in;
      end
   end

   sha1s_msg u_msg (
      .clock   (clock),
      .msg_ctl (msg_ctl),
      .w_cur   (w_cur)
   );

   sha1s_round u_round (
      .clock       (clock),
      .reset       (reset),
      .rnd_ctl     (rnd_ctl),
      .w_cur       (w_cur),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == sha1s_pkg::LAST_INDEX);

   `ASSERT_HOLDS(a_round_count_idle, round_ff != 7'd0,
      state_ff == sha1s_pkg::ST_ROUND, "round counter running outside compression")
   `ASSERT_NEXT(a_round_to_add,
      state_ff == sha1s_pkg::ST_ROUND && round_ff == sha1s_pkg::LAST_ROUND,
      state_ff == sha1s_pkg::ST_ADD, "compression did not end after the last round")
   `ASSERT_HOLDS(a_emit_padded, rsp_valid, pad_ff && len_ok_ff && fill_ff == 6'd0,
      "digest shown before the length block was hashed")
   `ASSERT_NEXT(a_last_closes, rsp_valid && rsp_last_word && !rsp_stall,
      !rsp_valid && !req_stall && bits_ff == 64'd0,
      "message state not cleared after the last digest transfer")

endmodule

@@ bench/sha1_digest_checker.sv @@
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] IV [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   localparam logic [31:0] K_CH  = 32'h5A827999;
   localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
   localparam logic [31:0] K_P2  = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0]     chain_h [5];
   logic [63:0]     msg_bits;
   logic [7:0]      blk [64];
   int unsigned     blk_fill;
   digest_word_type digest_due_q [$];

   function automatic void fold_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) begin
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
         x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {x[30:0], x[31]};
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_P1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_P2;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
      chain_h[3] += d; chain_h[4] += e;
   endfunction

   function automatic void start_message();
      for (int i = 0; i < 5; i++) chain_h[i] = IV[i];
      msg_bits = '0;
      blk_fill = 0;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      blk[blk_fill] = b;
      blk_fill++;
      if (blk_fill == 64) begin
         fold_block();
         msg_bits += 64'd512;
         blk_fill = 0;
      end
   endfunction

   function automatic void finish_message();
      logic [63:0]     total;
      digest_word_type dw;
      total = msg_bits + 64'(blk_fill) * 64'd8;
      blk[blk_fill] = PAD_BYTE;
      blk_fill++;
      if (blk_fill > 56) begin
         while (blk_fill < 64) begin
            blk[blk_fill] = 8'h00;
            blk_fill++;
         end
         fold_block();
         blk_fill = 0;
      end
      while (blk_fill < 56) begin
         blk[blk_fill] = 8'h00;
         blk_fill++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
      fold_block();
      for (int i = 0; i < 5; i++) begin
         dw.word  = chain_h[i];
         dw.index = 3'(i);
         dw.last  = (i == 4);
         digest_due_q = {digest_due_q, dw};
      end
      start_message();
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         start_message();
         digest_due_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_due_q.size() == 0) begin
               report_mismatch("unexpected rsp transfer", 32'h0, rsp_digest_word);
            end else begin
               want = digest_due_q.pop_front();
               if (rsp_digest_word !== want.word)
                  report_mismatch("digest_word", want.word, rsp_digest_word);
               if (rsp_word_index !== want.index)
                  report_mismatch("word_index", 32'(want.index), 32'(rsp_word_index));
               if (rsp_last_word !== want.last)
                  report_mismatch("last_word", 32'(want.last), 32'(rsp_last_word));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_action == sha1s_pkg::ACT_FINISH) finish_message();
            else absorb_byte(req_data_byte);
         end
      end
      words_pending = digest_due_q.size();
   end

endmodule

@@ bench/sha1_stream_hasher_unit_tb.sv @@
module sha1_stream_hasher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 200;
   localparam int ITEM_TARGET   = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = sha1s_pkg::ACT_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   int          fail_count;
   int          words_pending;
   int          quiet_cycles = 0;
   int          items_sent = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   always #5 clock = ~clock;

   sha1_stream_hasher_unit dut (.*);

   sha1_digest_checker checker_i (.*);

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called and returns at a falling edge; valid stays high after the transfer
   task automatic send_item(input logic act, input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_item(sha1s_pkg::ACT_ABSORB, 8'($urandom_range(255)));
      end
      send_item(sha1s_pkg::ACT_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic set_idle_mix();
      if (items_sent < ITEM_TARGET / 3) begin
         req_idle_pct = 38;
         rsp_idle_pct = 57;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         req_idle_pct = 57;
         rsp_idle_pct = 38;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   initial begin
      int kind;
      int len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idle_mix();

      // empty message, then a finish right after a finish with a junk byte, then two short messages
      send_item(sha1s_pkg::ACT_FINISH, 8'h00);
      send_item(sha1s_pkg::ACT_FINISH, 8'hFF);
      send_item(sha1s_pkg::ACT_ABSORB, 8'h00);
      send_item(sha1s_pkg::ACT_ABSORB, 8'hFF);
      send_item(sha1s_pkg::ACT_FINISH, 8'h5A);
      send_item(sha1s_pkg::ACT_ABSORB, 8'h61);
      send_item(sha1s_pkg::ACT_ABSORB, 8'h62);
      send_item(sha1s_pkg::ACT_ABSORB, 8'h63);
      send_item(sha1s_pkg::ACT_FINISH, 8'hA5);

      while (items_sent < ITEM_TARGET) begin
         set_idle_mix();
         kind = $urandom_range(11);
         case (kind)
            6:       len = 55;
            7:       len = 56;
            8:       len = 63;
            9:       len = 64;
            10:      len = $urandom_range(70, 65);
            11:      len = $urandom_range(130, 1);
            default: len = $urandom_range(6);
         endcase
         if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
         send_message(len);
      end

      req_valid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
